/* rtl/servo_bus_frame_receiver_assert.svh */
// ----------------------------------------------------------------------------
// servo_bus_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_FRAME_RECEIVER_ASSERT_SVH
`define SERVO_BUS_FRAME_RECEIVER_ASSERT_SVH

// Single property, sampled on clk, off during reset.
`define SBFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define SBFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sbfr_pkg.sv */
// ----------------------------------------------------------------------------
// sbfr_pkg
// Types and constants shared by the servo bus frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbfr_pkg;

  localparam logic [7:0] HEADER_RESET   = 8'h55;
  localparam logic [3:0] LENGTH_RESET   = 4'd2;
  localparam logic [7:0] MIN_LENGTH     = 8'd3;
  // id and length bytes sit ahead of the payload
  localparam logic [3:0] PAYLOAD_OFFSET = 4'd2;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_CSUM_ERR = 1'b1
  } status_t;

  typedef struct packed {
    logic       csum_err;
    logic [7:0] servo_id;
  } frame_tag_t;

endpackage

/* rtl/sbfr_if.sv */
// ----------------------------------------------------------------------------
// sbfr_if
// Valid/ready channel interfaces: received bytes, results, configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfr_result_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] servo_id;
  logic [2:0] payload_index;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output status, output servo_id, output payload_index,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input status, input servo_id, input payload_index,
                  input payload_byte, input last, output ready);
endinterface

interface sbfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_value;

  modport source (output valid, output header_value, input ready);
  modport sink   (input valid, input header_value, output ready);
endinterface

/* rtl/sbfr_front.sv */
// ----------------------------------------------------------------------------
// sbfr_front
// Byte parser: header hunt, id/length capture, payload collection and
// checksum test. Pushes one finished frame record per checksum byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfr_front import sbfr_pkg::*; #(
  parameter int  MAX_LENGTH = 7,
  localparam int PAY_DEPTH  = MAX_LENGTH - 2,
  localparam int IDX_W      = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1,
  localparam int CNT_W      = $clog2(PAY_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  sbfr_rx_if.sink                     rx,
  input  logic [7:0]                  header_value,
  output logic                        push_valid,
  input  logic                        push_ready,
  output frame_tag_t                  push_tag,
  output logic [CNT_W-1:0]            push_count,
  output logic [PAY_DEPTH-1:0][7:0]   push_payload
);

  localparam logic [7:0] MAX_LEN_B = 8'(MAX_LENGTH);

  logic                      header_seen;
  logic                      in_frame;
  logic [3:0]                byte_position;
  logic [3:0]                frame_length;
  logic [7:0]                running_sum;
  logic [7:0]                frame_id;
  logic [PAY_DEPTH-1:0][7:0] payload_store;

  logic accept;
  logic in_body;
  logic is_payload;
  logic is_csum;

  assign in_body    = in_frame && (byte_position >= PAYLOAD_OFFSET);
  assign is_payload = in_body && (byte_position < frame_length);
  assign is_csum    = in_body && !(byte_position < frame_length);

  // only the checksum byte needs room in the queue
  assign rx.ready   = !is_csum || push_ready;
  assign accept     = rx.valid && rx.ready;

  assign push_valid        = rx.valid && is_csum;
  assign push_tag.csum_err = (rx.rx_byte != ~running_sum);
  assign push_tag.servo_id = frame_id;
  assign push_count        = CNT_W'(frame_length - PAYLOAD_OFFSET);
  assign push_payload      = payload_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen   <= 1'b0;
      in_frame      <= 1'b0;
      byte_position <= 4'd0;
      frame_length  <= LENGTH_RESET;
      running_sum   <= 8'd0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx.rx_byte == header_value) begin
          if (header_seen) begin
            header_seen   <= 1'b0;
            in_frame      <= 1'b1;
            byte_position <= 4'd0;
            running_sum   <= 8'd0;
          end else begin
            header_seen <= 1'b1;
          end
        end else begin
          header_seen <= 1'b0;
        end
      end else if (byte_position == 4'd0) begin
        running_sum   <= rx.rx_byte;
        byte_position <= 4'd1;
      end else if (byte_position == 4'd1) begin
        if ((rx.rx_byte < MIN_LENGTH) || (rx.rx_byte > MAX_LEN_B)) begin
          in_frame      <= 1'b0;
          header_seen   <= 1'b0;
          byte_position <= 4'd0;
          frame_length  <= LENGTH_RESET;
        end else begin
          frame_length  <= rx.rx_byte[3:0];
          running_sum   <= running_sum + rx.rx_byte;
          byte_position <= PAYLOAD_OFFSET;
        end
      end else if (is_payload) begin
        running_sum   <= running_sum + rx.rx_byte;
        byte_position <= byte_position + 4'd1;
      end else begin
        // checksum byte closes the frame
        in_frame      <= 1'b0;
        header_seen   <= 1'b0;
        byte_position <= 4'd0;
        frame_length  <= LENGTH_RESET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame && (byte_position == 4'd0)) begin
      frame_id <= rx.rx_byte;
    end
    if (accept && is_payload) begin
      payload_store[IDX_W'(byte_position - PAYLOAD_OFFSET)] <= rx.rx_byte;
    end
  end

endmodule

/* rtl/sbfr_queue.sv */
// ----------------------------------------------------------------------------
// sbfr_queue
// Small register FIFO of frame records between parser and result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfr_queue #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [DEPTH-1:0][WIDTH-1:0] entries;
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [PTR_W:0]              fill;

  logic do_push;
  logic do_pop;

  assign push_ready = (fill != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/sbfr_back.sv */
// ----------------------------------------------------------------------------
// sbfr_back
// Result stage: unpacks one frame record into result transactions, one per
// cycle while result.ready allows, into a registered output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbfr_back import sbfr_pkg::*; #(
  parameter int  MAX_LENGTH = 7,
  localparam int PAY_DEPTH  = MAX_LENGTH - 2,
  localparam int CNT_W      = $clog2(PAY_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  frame_tag_t                pop_tag,
  input  logic [CNT_W-1:0]          pop_count,
  input  logic [PAY_DEPTH-1:0][7:0] pop_payload,
  sbfr_result_if.source             result
);

  logic                      busy;
  frame_tag_t                cur_tag;
  logic [CNT_W-1:0]          remain;
  logic [2:0]                index;
  logic [PAY_DEPTH-1:0][7:0] cur_payload;

  logic issue;
  logic is_last;
  logic load;

  assign issue     = busy && (!result.valid || result.ready);
  assign is_last   = cur_tag.csum_err || (remain == CNT_W'(1));
  assign pop_ready = !busy || (issue && is_last);
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (issue) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (issue && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_tag     <= pop_tag;
      remain      <= pop_count;
      index       <= 3'd0;
      cur_payload <= pop_payload;
    end else if (issue) begin
      remain      <= remain - 1'b1;
      index       <= index + 3'd1;
      cur_payload <= cur_payload >> 8;
    end
    if (issue) begin
      result.servo_id <= cur_tag.servo_id;
      result.last     <= is_last;
      if (cur_tag.csum_err) begin
        result.status        <= ST_CSUM_ERR;
        result.payload_index <= 3'd0;
        result.payload_byte  <= 8'd0;
      end else begin
        result.status        <= ST_OK;
        result.payload_index <= index;
        result.payload_byte  <= cur_payload[0];
      end
    end
  end

endmodule

/* rtl/servo_bus_frame_receiver.sv */
// ----------------------------------------------------------------------------
// servo_bus_frame_receiver
// Throughput: one received byte per cycle, held back at a checksum byte while
// the frame queue is full; results leave one per cycle while not stalled. A
// two-entry frame queue lets parser and result stage stall apart.
// Reset (synchronous, rst high): hunting for header, queue empty, no result
// pending, header value back to 0x55.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_bus_frame_receiver import sbfr_pkg::*; #(
  parameter int MAX_LENGTH = 7
) (
  input  logic          clk,
  input  logic          rst,
  sbfr_rx_if.sink       rx,
  sbfr_result_if.source result,
  sbfr_cfg_if.sink      cfg
);

  localparam int PAY_DEPTH = MAX_LENGTH - 2;
  localparam int CNT_W     = $clog2(PAY_DEPTH + 1);
  localparam int ENTRY_W   = $bits(frame_tag_t) + CNT_W + PAY_DEPTH * 8;
  localparam int Q_DEPTH   = 2;

  logic [7:0] header_value;

  logic                      push_valid;
  logic                      push_ready;
  frame_tag_t                push_tag;
  logic [CNT_W-1:0]          push_count;
  logic [PAY_DEPTH-1:0][7:0] push_payload;

  logic                      pop_valid;
  logic                      pop_ready;
  logic [ENTRY_W-1:0]        pop_data;
  frame_tag_t                pop_tag;
  logic [CNT_W-1:0]          pop_count;
  logic [PAY_DEPTH-1:0][7:0] pop_payload;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
    end else if (cfg.valid) begin
      header_value <= cfg.header_value;
    end
  end

  sbfr_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .header_value (header_value),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_tag     (push_tag),
    .push_count   (push_count),
    .push_payload (push_payload)
  );

  sbfr_queue #(.WIDTH(ENTRY_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_tag, push_count, push_payload}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_tag, pop_count, pop_payload} = pop_data;

  sbfr_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_tag     (pop_tag),
    .pop_count   (pop_count),
    .pop_payload (pop_payload),
    .result      (result)
  );

endmodule

/* rtl/sbfr_checker.sv */
// ----------------------------------------------------------------------------
// sbfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_bus_frame_receiver_assert.svh"

module sbfr_checker import sbfr_pkg::*; #(
  parameter int MAX_LENGTH = 7
) (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_status,
  input logic [7:0] res_id,
  input logic [2:0] res_index,
  input logic [7:0] res_byte,
  input logic       res_last
);

  localparam logic [2:0] MAX_INDEX = 3'(MAX_LENGTH - 3);

  // track the previous result transaction of the current frame
  logic       first_expected;
  logic [2:0] prev_index;
  logic [7:0] prev_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_expected <= 1'b1;
      prev_index     <= 3'd0;
      prev_id        <= 8'd0;
    end else if (res_valid && res_ready) begin
      first_expected <= res_last;
      prev_index     <= res_index;
      prev_id        <= res_id;
    end
  end

  `SBFR_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(res_id) && $stable(res_index) && $stable(res_byte) && $stable(res_last) && $stable(res_status), "result changed while stalled")
  `SBFR_ASSERT(a_error_shape, (res_valid && (res_status == ST_CSUM_ERR) |-> res_last && (res_index == 3'd0) && (res_byte == 8'd0)), "malformed checksum error result")
  `SBFR_ASSERT(a_index_order, (res_valid |-> (first_expected ? (res_index == 3'd0) : (res_index == prev_index + 3'd1))), "payload index out of order")
  `SBFR_ASSERT(a_index_bound, (res_valid |-> (res_index <= MAX_INDEX)), "payload index beyond frame limit")
  `SBFR_ASSERT(a_id_steady, (res_valid && !first_expected |-> (res_id == prev_id)), "servo id changed within a frame")

endmodule

bind servo_bus_frame_receiver sbfr_checker #(.MAX_LENGTH(MAX_LENGTH)) u_sbfr_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_status(result.status),
  .res_id    (result.servo_id),
  .res_index (result.payload_index),
  .res_byte  (result.payload_byte),
  .res_last  (result.last)
);

/* verif/servo_bus_frame_receiver_tb.sv */
// ----------------------------------------------------------------------------
// servo_bus_frame_receiver_tb
// Self-checking bench for the servo bus frame receiver. Received bytes go
// in over a valid/ready channel. A short table of directed bytes comes first;
// its checksum rows carry their own expected results. An in-bench parser
// model predicts every other result: payload bytes of good frames, and
// checksum errors. Random frame traffic follows, under several header values,
// with random idling on both sides, a long result stall and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_bus_frame_receiver_tb;
  import sbfr_pkg::*;

  localparam int MAX_LEN       = 7;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int N_DIRECTED    = 22;

  typedef struct packed {
    status_t    status;
    logic [7:0] servo_id;
    logic [2:0] payload_index;
    logic [7:0] payload_byte;
    logic       last;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          typed;
    frame_result_t res;
  } stim_row_t;

  localparam frame_result_t NO_RES = '{ST_OK, 8'h00, 3'd0, 8'h00, 1'b0};

  // Typed results sit on checksum bytes only.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h55, 1'b0, NO_RES},
    '{8'h12, 1'b0, NO_RES},  // breaks the header pair
    '{8'h55, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},  // id equal to header value
    '{8'h03, 1'b0, NO_RES},  // shortest length
    '{8'hFF, 1'b0, NO_RES},
    '{8'hA8, 1'b1, '{ST_OK, 8'h55, 3'd0, 8'hFF, 1'b1}},
    '{8'h55, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{ST_CSUM_ERR, 8'hFF, 3'd0, 8'h00, 1'b1}},
    '{8'h55, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},  // length too short, dropped
    '{8'h55, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h08, 1'b0, NO_RES}   // length too long, dropped
  };

  logic clk;
  logic rst;

  sbfr_rx_if     rx_link ();
  sbfr_result_if result_link ();
  sbfr_cfg_if    cfg_link ();

  servo_bus_frame_receiver #(.MAX_LENGTH(MAX_LEN)) dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_link),
    .result (result_link),
    .cfg    (cfg_link)
  );

  // parser model state
  logic [7:0] header_cfg;
  logic       hunt_hdr_seen;
  logic       in_frame_m;
  logic [3:0] frame_pos;
  logic [3:0] frame_len;
  logic [7:0] frame_sum;
  logic [7:0] frame_id_m;
  logic [7:0] payload_buf [8];

  frame_result_t pending_results [$];
  frame_result_t frame_outputs [$];

  int  fail_count;
  int  bytes_sent;
  int  results_checked;
  int  csum_errs_seen;
  int  header_writes;
  int  cycle_count;
  int  hold_requests;
  int  hold_granted;
  int  hold_left;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void close_frame();
    in_frame_m    = 1'b0;
    hunt_hdr_seen = 1'b0;
    frame_pos     = 4'd0;
    frame_len     = LENGTH_RESET;
  endfunction

  // Advances the parser model by one byte; new results land in frame_outputs.
  function automatic void parse_rx_byte(input logic [7:0] b);
    frame_result_t r;
    int            n_pay;
    frame_outputs.delete();
    if (!in_frame_m) begin
      if (b == header_cfg) begin
        if (hunt_hdr_seen) begin
          hunt_hdr_seen = 1'b0;
          in_frame_m    = 1'b1;
          frame_pos     = 4'd0;
          frame_sum     = 8'h00;
        end else begin
          hunt_hdr_seen = 1'b1;
        end
      end else begin
        hunt_hdr_seen = 1'b0;
      end
    end else if (frame_pos == 4'd0) begin
      frame_id_m = b;
      frame_sum  = b;
      frame_pos  = 4'd1;
    end else if (frame_pos == 4'd1) begin
      if (b < MIN_LENGTH || b > 8'(MAX_LEN)) begin
        close_frame();
      end else begin
        frame_len = b[3:0];
        frame_sum = frame_sum + b;
        frame_pos = PAYLOAD_OFFSET;
      end
    end else if (frame_pos < frame_len) begin
      payload_buf[3'(frame_pos - PAYLOAD_OFFSET)] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      if (~frame_sum != b) begin
        r = '{ST_CSUM_ERR, frame_id_m, 3'd0, 8'h00, 1'b1};
        frame_outputs.push_back(r);
      end else begin
        n_pay = int'(frame_len) - int'(PAYLOAD_OFFSET);
        for (int k = 0; k < n_pay; k++) begin
          r = '{ST_OK, frame_id_m, 3'(k), payload_buf[k], (k == n_pay - 1)};
          frame_outputs.push_back(r);
        end
      end
      close_frame();
    end
  endfunction

  // Leaves valid high afterwards so back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_result_t res);
    while (!calm && $urandom_range(99) < 17) begin
      rx_link.valid <= 1'b0;
      @(posedge clk);
    end
    rx_link.valid   <= 1'b1;
    rx_link.rx_byte <= b;
    @(posedge clk);
    while (!rx_link.ready) @(posedge clk);
    bytes_sent++;
    parse_rx_byte(b);
    if (typed) begin
      pending_results.push_back(res);
    end else begin
      foreach (frame_outputs[i]) pending_results.push_back(frame_outputs[i]);
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    rx_link.valid <= 1'b0;
    drain();
    cfg_link.valid        <= 1'b1;
    cfg_link.header_value <= v;
    @(posedge clk);
    while (!cfg_link.ready) @(posedge clk);
    cfg_link.valid <= 1'b0;
    header_cfg = v;
    header_writes++;
  endtask

  // Biased toward the header value and the byte extremes.
  function automatic logic [7:0] any_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return header_cfg;
    if (r < 30) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_traffic(input int n_bytes, input bit pause_midway);
    logic [7:0] chunk [$];
    logic [7:0] b;
    logic [7:0] sum;
    int         kind;
    int         plen;
    int         sent;
    bit         paused;
    sent   = 0;
    paused = 0;
    while (sent < n_bytes) begin
      chunk.delete();
      kind = $urandom_range(99);
      chunk.push_back(header_cfg);
      if (kind < 75) begin
        // well-formed frame, sometimes with a corrupted checksum
        plen = ($urandom_range(99) < 30) ? MAX_LEN : $urandom_range(MAX_LEN, 3);
        chunk.push_back(header_cfg);
        b = any_byte();
        chunk.push_back(b);
        sum = b + 8'(plen);
        chunk.push_back(8'(plen));
        repeat (plen - 2) begin
          b = any_byte();
          chunk.push_back(b);
          sum = sum + b;
        end
        b = ~sum;
        if ($urandom_range(99) < 20) b = b ^ 8'($urandom_range(255, 1));
        chunk.push_back(b);
      end else if (kind < 85) begin
        chunk.push_back(header_cfg);
        chunk.push_back(any_byte());
        if ($urandom_range(1) != 0) chunk.push_back(8'($urandom_range(2, 0)));
        else chunk.push_back(8'($urandom_range(255, 8)));
      end else if (kind < 95) begin
        chunk.delete();
        repeat ($urandom_range(4, 1)) chunk.push_back(any_byte());
      end else begin
        // truncated frame: what follows is taken as its tail
        chunk.push_back(header_cfg);
        chunk.push_back(any_byte());
        chunk.push_back(8'($urandom_range(MAX_LEN, 3)));
        chunk.push_back(any_byte());
      end
      foreach (chunk[i]) send_byte(chunk[i], 1'b0, NO_RES);
      sent += chunk.size();
      if (pause_midway && !paused && sent >= n_bytes / 2) begin
        rx_link.valid <= 1'b0;
        drain();
        paused = 1;
      end
    end
  endtask

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got = '{status_t'(result_link.status), result_link.servo_id, result_link.payload_index,
            result_link.payload_byte, result_link.last};
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (got.status == ST_CSUM_ERR) csum_errs_seen++;
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("servo_id", want.servo_id, got.servo_id);
      compare_field("payload_index", 8'(want.payload_index), 8'(got.payload_index));
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("last", 8'(want.last), 8'(got.last));
    end
  endtask

  // result side: checks transactions and drives ready
  initial begin
    result_link.ready <= 1'b0;
    hold_granted = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_link.valid && result_link.ready) check_result();
      if (hold_granted < hold_requests) begin
        hold_granted++;
        hold_left = LONG_HOLD;
      end
      if (rst) begin
        result_link.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_link.ready <= 1'b0;
      end else begin
        result_link.ready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("servo_bus_frame_receiver test failed");
    $finish;
  end

  initial begin
    fail_count      = 0;
    bytes_sent      = 0;
    results_checked = 0;
    csum_errs_seen  = 0;
    header_writes   = 0;
    hold_requests   = 0;
    calm            = 0;
    header_cfg      = HEADER_RESET;
    close_frame();
    frame_sum  = 8'h00;
    frame_id_m = 8'h00;
    rst                   <= 1'b1;
    rx_link.valid         <= 1'b0;
    rx_link.rx_byte       <= 8'h00;
    cfg_link.valid        <= 1'b0;
    cfg_link.header_value <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].res);
    end

    // long result stall while frames keep coming
    write_header(8'h00);
    hold_requests++;
    random_traffic(60, 1'b0);

    // no idling on either side
    write_header(8'hFF);
    calm = 1;
    random_traffic(60, 1'b0);
    rx_link.valid <= 1'b0;
    drain();
    calm = 0;

    write_header(8'($urandom_range(255)));
    random_traffic(60, 1'b1);

    write_header(HEADER_RESET);
    random_traffic(80, 1'b0);

    rx_link.valid <= 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes under %0d header settings; checked %0d results, %0d of them",
             bytes_sent, header_writes + 1, results_checked, csum_errs_seen);
    $display("checksum errors, with one long result stall and one full drain pause.");
    if (fail_count == 0) begin
      $display("servo_bus_frame_receiver test passed");
    end else begin
      $display("servo_bus_frame_receiver test failed");
    end
    $finish;
  end

endmodule
